FILE: sv/mksol_pkg.sv
// ----------------------------------------------------------------------------
// mksol_pkg
// shared types, register codes and the key compare used by the sort cells
// ----------------------------------------------------------------------------
package mksol_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 64;
    localparam int KEY_W_MAX     = 64;
    localparam int CFG_W         = 7;
    localparam int ADDR_W        = 5;
    localparam int REG_IDX_W     = 3;

    localparam logic [REG_IDX_W-1:0] REG_SLICE_OFFSET     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SLICE_LIMIT      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_A_DESCENDING = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY_B_ENABLED    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KEY_B_DESCENDING = 3'd4;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT,
        ST_SKIP,
        ST_EMIT,
        ST_EMPTY
    } t_state;

    typedef struct packed {
        logic load;
        logic sort;
        logic phase;
        logic shift;
        logic a_desc;
        logic b_en;
        logic b_desc;
    } t_cell_ctl;

    typedef struct packed {
        logic first;
        logic tie;
    } t_key_cmp;

    // keys arrive with the sign bit flipped, so unsigned order is signed order
    function automatic t_key_cmp key_cmp(
        input logic [KEY_W_MAX-1:0] kx,
        input logic                 nx,
        input logic [KEY_W_MAX-1:0] ky,
        input logic                 ny,
        input logic                 desc
    );
        t_key_cmp c;
        c.first = 1'b0;
        c.tie   = 1'b0;
        if (nx && ny) begin
            c.tie = 1'b1;
        end else if (nx) begin
            c.first = 1'b0;
        end else if (ny) begin
            c.first = 1'b1;
        end else if (kx == ky) begin
            c.tie = 1'b1;
        end else if (kx < ky) begin
            c.first = !desc;
        end else begin
            c.first = desc;
        end
        return c;
    endfunction

endpackage

FILE: sv/mksol_cell.sv
// ----------------------------------------------------------------------------
// mksol_cell
// one record slot of the sort chain: load, odd-even exchange, shift out
// ----------------------------------------------------------------------------
module mksol_cell #(
    parameter int CAPACITY  = mksol_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = mksol_pkg::KEY_WIDTH_DEF,
    parameter int IDX       = 0,
    localparam int CW       = $clog2(CAPACITY + 1),
    localparam int REC_W    = 66 + 2 * KEY_WIDTH
) (
    input  logic                  i_clk,
    input  mksol_pkg::t_cell_ctl  i_ctl,
    input  logic [CW-1:0]         i_count,
    input  logic [REC_W-1:0]      i_ld_rec,
    input  logic [REC_W-1:0]      i_left_rec,
    input  logic [REC_W-1:0]      i_right_rec,
    input  logic                  i_left_lt,
    output logic [REC_W-1:0]      o_rec,
    output logic                  o_lt
);
    import mksol_pkg::*;

    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] NEXT_C = CW'(IDX + 1);
    localparam logic          PAR    = 1'((IDX % 2));

    logic [REC_W-1:0] r_rec;
    logic [REC_W-1:0] n_rec;
    t_key_cmp         w_ca;
    t_key_cmp         w_cb;
    logic             w_right_ok;
    logic             w_self_ok;

    // record layout: row, score, key a n/a, key a, key b n/a, key b
    always_comb begin
        w_ca = key_cmp(KEY_W_MAX'(i_right_rec[2*KEY_WIDTH:KEY_WIDTH+1]),
                       i_right_rec[2*KEY_WIDTH+1],
                       KEY_W_MAX'(r_rec[2*KEY_WIDTH:KEY_WIDTH+1]),
                       r_rec[2*KEY_WIDTH+1], i_ctl.a_desc);
        w_cb = key_cmp(KEY_W_MAX'(i_right_rec[KEY_WIDTH-1:0]), i_right_rec[KEY_WIDTH],
                       KEY_W_MAX'(r_rec[KEY_WIDTH-1:0]), r_rec[KEY_WIDTH],
                       i_ctl.b_desc);
        o_lt = w_ca.first || (w_ca.tie && i_ctl.b_en && w_cb.first);
    end

    always_comb begin
        w_right_ok = NEXT_C < i_count;
        w_self_ok  = (IDX != 0) && (IDX_C < i_count);
        n_rec      = r_rec;
        if (i_ctl.load && (i_count == IDX_C)) begin
            n_rec = i_ld_rec;
        end else if (i_ctl.sort) begin
            if (i_ctl.phase == PAR) begin
                if (o_lt && w_right_ok) begin
                    n_rec = i_right_rec;
                end
            end else if (i_left_lt && w_self_ok) begin
                n_rec = i_left_rec;
            end
        end else if (i_ctl.shift) begin
            n_rec = i_right_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

endmodule

FILE: sv/multi_key_sort_offset_limit_core.sv
// ----------------------------------------------------------------------------
// multi_key_sort_offset_limit_core
// loads records into a chain of cells, sorts by odd-even exchange, drains the slice
// throughput: one item per cycle while loading, input held from last item to last result
// after the last item the chain sorts, shifts out slice_offset records, then drains the slice
// (an empty slice skips the shift-out and yields one empty result), one result per cycle while the consumer is ready
// reset (synchronous, active low) empties the set and restores register defaults
// ----------------------------------------------------------------------------
module multi_key_sort_offset_limit_core #(
    parameter int CAPACITY  = mksol_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = mksol_pkg::KEY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mksol_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [31:0]                   i_row_id,
    input  logic [31:0]                   i_score_bits,
    input  logic [KEY_WIDTH-1:0]          i_key_a,
    input  logic                          i_key_a_na,
    input  logic [KEY_WIDTH-1:0]          i_key_b,
    input  logic                          i_key_b_na,
    input  logic                          i_last_record,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [31:0]                   o_out_row_id,
    output logic [31:0]                   o_out_score_bits,
    output logic                          o_record_valid,
    output logic                          o_overflowed,
    output logic                          o_last_result
);
    import mksol_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int RW    = $clog2(CAPACITY);
    localparam int REC_W = 66 + 2 * KEY_WIDTH;

    t_state             r_state;
    t_state             n_state;
    logic [CW-1:0]      r_count;
    logic               r_ovf;
    logic               r_ovf_set;
    logic [RW-1:0]      r_rounds;
    logic               r_phase;
    logic [CFG_W-1:0]   r_skip;
    logic [CFG_W-1:0]   r_remain;
    logic [CFG_W-1:0]   r_offset;
    logic [CFG_W-1:0]   r_limit;
    logic               r_a_desc;
    logic               r_b_en;
    logic               r_b_desc;
    logic               r_out_valid;
    logic [31:0]        r_out_row;
    logic [31:0]        r_out_score;
    logic               r_out_rec_valid;
    logic               r_out_ovf;
    logic               r_out_last;

    t_cell_ctl          w_ctl;
    logic               w_in_acc;
    logic               w_full;
    logic               w_take;
    logic               w_emit;
    logic               w_empty_emit;
    logic               w_sort_end;
    logic               w_empty;
    logic [CFG_W-1:0]   w_avail;
    logic [CFG_W-1:0]   w_remain;
    logic [REC_W-1:0]   w_ld_rec;
    logic [REC_W-1:0]   w_rec [0:CAPACITY+1];
    logic               w_lt  [0:CAPACITY];
    logic               w_cfg_wr;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_SLICE_OFFSET:     prdata = 32'(r_offset);
            REG_SLICE_LIMIT:      prdata = 32'(r_limit);
            REG_KEY_A_DESCENDING: prdata = 32'(r_a_desc);
            REG_KEY_B_ENABLED:    prdata = 32'(r_b_en);
            REG_KEY_B_DESCENDING: prdata = 32'(r_b_desc);
            default:              prdata = '0;
        endcase
    end

    // record entering the chain, keys sign-flipped for unsigned compare
    assign w_ld_rec = {i_row_id, i_score_bits,
                       i_key_a_na, ~i_key_a[KEY_WIDTH-1], i_key_a[KEY_WIDTH-2:0],
                       i_key_b_na, ~i_key_b[KEY_WIDTH-1], i_key_b[KEY_WIDTH-2:0]};

    assign w_full     = r_count == CW'(CAPACITY);
    assign w_take     = !r_out_valid || i_out_ready;
    assign w_sort_end = r_rounds == RW'(CAPACITY - 1);
    assign w_avail    = CFG_W'(r_count) - r_offset;
    assign w_remain   = (r_limit < w_avail) ? r_limit : w_avail;
    assign w_empty    = (r_offset >= CFG_W'(r_count)) || (r_limit == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (i_in_valid && i_last_record) begin
                    n_state = ST_SORT;
                end
            end
            ST_SORT: begin
                if (w_sort_end) begin
                    n_state = w_empty ? ST_EMPTY : ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (r_skip == '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_take && (r_remain == CFG_W'(1))) begin
                    n_state = ST_LOAD;
                end
            end
            ST_EMPTY: begin
                if (w_take) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready    = r_state == ST_LOAD;
        w_in_acc      = i_in_valid && o_in_ready;
        w_emit        = (r_state == ST_EMIT) && w_take;
        w_empty_emit  = (r_state == ST_EMPTY) && w_take;
        w_ctl.load    = w_in_acc && !w_full;
        w_ctl.sort    = r_state == ST_SORT;
        w_ctl.phase   = r_phase;
        w_ctl.shift   = ((r_state == ST_SKIP) && (r_skip != '0)) || w_emit;
        w_ctl.a_desc  = r_a_desc;
        w_ctl.b_en    = r_b_en;
        w_ctl.b_desc  = r_b_desc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_rounds    <= '0;
            r_phase     <= 1'b0;
            r_skip      <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
            r_offset    <= '0;
            r_limit     <= CFG_W'(64);
            r_a_desc    <= 1'b0;
            r_b_en      <= 1'b0;
            r_b_desc    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                case (paddr[ADDR_W-1:2])
                    REG_SLICE_OFFSET:     r_offset <= pwdata[CFG_W-1:0];
                    REG_SLICE_LIMIT:      r_limit  <= pwdata[CFG_W-1:0];
                    REG_KEY_A_DESCENDING: r_a_desc <= pwdata[0];
                    REG_KEY_B_ENABLED:    r_b_en   <= pwdata[0];
                    REG_KEY_B_DESCENDING: r_b_desc <= pwdata[0];
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
                r_rounds <= '0;
                r_phase  <= 1'b0;
            end
            if (r_state == ST_SORT) begin
                r_rounds <= r_rounds + RW'(1);
                r_phase  <= !r_phase;
                r_skip   <= r_offset;
                r_remain <= w_remain;
            end
            if ((r_state == ST_SKIP) && (r_skip != '0)) begin
                r_skip <= r_skip - CFG_W'(1);
            end
            if (w_emit || w_empty_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_emit) begin
                r_remain <= r_remain - CFG_W'(1);
                if (r_remain == CFG_W'(1)) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
            end
            if (w_empty_emit) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_last_record) begin
            r_ovf_set <= r_ovf || w_full;
        end
        if (w_emit) begin
            r_out_row       <= w_rec[1][REC_W-1 -: 32];
            r_out_score     <= w_rec[1][REC_W-33 -: 32];
            r_out_rec_valid <= 1'b1;
            r_out_ovf       <= r_ovf_set;
            r_out_last      <= r_remain == CFG_W'(1);
        end else if (w_empty_emit) begin
            r_out_row       <= '0;
            r_out_score     <= '0;
            r_out_rec_valid <= 1'b0;
            r_out_ovf       <= r_ovf_set;
            r_out_last      <= 1'b1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_row_id     = r_out_row;
    assign o_out_score_bits = r_out_score;
    assign o_record_valid   = r_out_rec_valid;
    assign o_overflowed     = r_out_ovf;
    assign o_last_result    = r_out_last;

    // cell chain, cell g sits at w_rec[g+1]
    assign w_rec[0]          = '0;
    assign w_rec[CAPACITY+1] = '0;
    assign w_lt[0]           = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        mksol_cell #(
            .CAPACITY  (CAPACITY),
            .KEY_WIDTH (KEY_WIDTH),
            .IDX       (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_ld_rec    (w_ld_rec),
            .i_left_rec  (w_rec[g]),
            .i_right_rec (w_rec[g+2]),
            .i_left_lt   (w_lt[g]),
            .o_rec       (w_rec[g+1]),
            .o_lt        (w_lt[g+1])
        );
    end

endmodule

FILE: tb/sv/multi_key_sort_offset_limit_core_test.sv
// ----------------------------------------------------------------------------
// multi_key_sort_offset_limit_core_test
// Loads record sets into the sort core. Each set is ordered by key A and,
// when key B is enabled, by key B, and the configured slice is read back.
// A local predictor does a stable insertion sort of each set. It queues the
// results that the offset and limit select, and every result is checked
// field by field. The test covers extreme keys, N/A keys, empty slices,
// long limits, store overflow, an unused register address, a long consumer
// stall, and random sets under random idle gaps on both sides.
// ----------------------------------------------------------------------------
module multi_key_sort_offset_limit_core_test;
    import mksol_pkg::*;

    localparam int CAP   = CAPACITY_DEF;
    localparam int KEY_W = KEY_WIDTH_DEF;
    localparam logic [REG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct packed {
        logic [31:0]      row_id;
        logic [31:0]      score;
        logic [KEY_W-1:0] key_a;
        logic             key_a_na;
        logic [KEY_W-1:0] key_b;
        logic             key_b_na;
        logic             last;
    } t_record;

    typedef struct packed {
        logic [31:0] row_id;
        logic [31:0] score;
        logic        valid;
        logic        ovf;
        logic        last;
    } t_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [31:0]       i_row_id = '0;
    logic [31:0]       i_score_bits = '0;
    logic [KEY_W-1:0]  i_key_a = '0;
    logic              i_key_a_na = 1'b0;
    logic [KEY_W-1:0]  i_key_b = '0;
    logic              i_key_b_na = 1'b0;
    logic              i_last_record = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [31:0]       o_out_row_id;
    logic [31:0]       o_out_score_bits;
    logic              o_record_valid;
    logic              o_overflowed;
    logic              o_last_result;

    logic [CFG_W-1:0] cfg_offset = 7'd0;
    logic [CFG_W-1:0] cfg_limit  = 7'd64;
    logic             cfg_a_desc = 1'b0;
    logic             cfg_b_en   = 1'b0;
    logic             cfg_b_desc = 1'b0;

    t_record loaded_records[$];
    logic    dropped_flag = 1'b0;
    t_result slice_queue[$];
    int      mismatch_count = 0;
    bit      steady = 1'b0;
    int      hold_off_cycles = 0;

    multi_key_sort_offset_limit_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_row_id         (i_row_id),
        .i_score_bits     (i_score_bits),
        .i_key_a          (i_key_a),
        .i_key_a_na       (i_key_a_na),
        .i_key_b          (i_key_b),
        .i_key_b_na       (i_key_b_na),
        .i_last_record    (i_last_record),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_row_id     (o_out_row_id),
        .o_out_score_bits (o_out_score_bits),
        .o_record_valid   (o_record_valid),
        .o_overflowed     (o_overflowed),
        .o_last_result    (o_last_result)
    );

    always #2 i_clk = ~i_clk;

    // -1 when x goes first, 1 when y goes first, 0 on a tie
    function automatic int key_order(input logic [KEY_W-1:0] kx, input logic nx,
                                     input logic [KEY_W-1:0] ky, input logic ny,
                                     input logic desc);
        logic [KEY_W-1:0] bx;
        logic [KEY_W-1:0] by;
        bx = kx ^ KEY_MIN;
        by = ky ^ KEY_MIN;
        if (nx && ny) return 0;
        if (nx) return 1;
        if (ny) return -1;
        if (bx == by) return 0;
        if (bx < by) return desc ? 1 : -1;
        return desc ? -1 : 1;
    endfunction

    function automatic void absorb_record(input t_record r);
        int      order[CAP];
        int      n, i, j, t, c, first, stop;
        t_result res;
        if (loaded_records.size() < CAP) begin
            loaded_records.push_back(r);
        end else begin
            dropped_flag = 1'b1;
        end
        if (!r.last) return;
        n = loaded_records.size();
        for (i = 0; i < n; i++) begin
            order[i] = i;
            for (j = i; j > 0; j--) begin
                c = key_order(loaded_records[order[j]].key_a, loaded_records[order[j]].key_a_na,
                              loaded_records[order[j-1]].key_a,
                              loaded_records[order[j-1]].key_a_na, cfg_a_desc);
                if (c == 0 && cfg_b_en) begin
                    c = key_order(loaded_records[order[j]].key_b,
                                  loaded_records[order[j]].key_b_na,
                                  loaded_records[order[j-1]].key_b,
                                  loaded_records[order[j-1]].key_b_na, cfg_b_desc);
                end
                if (c >= 0) break;
                t = order[j];
                order[j] = order[j-1];
                order[j-1] = t;
            end
        end
        res.ovf = dropped_flag;
        if (int'(cfg_offset) >= n || cfg_limit == 0) begin
            res.row_id = '0;
            res.score  = '0;
            res.valid  = 1'b0;
            res.last   = 1'b1;
            slice_queue.push_back(res);
        end else begin
            first = int'(cfg_offset);
            stop  = (int'(cfg_limit) <= n - first) ? first + int'(cfg_limit) : n;
            for (i = first; i < stop; i++) begin
                res.row_id = loaded_records[order[i]].row_id;
                res.score  = loaded_records[order[i]].score;
                res.valid  = 1'b1;
                res.last   = (i + 1 == stop);
                slice_queue.push_back(res);
            end
        end
        loaded_records = {};
        dropped_flag = 1'b0;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return int'($urandom_range(1, 3));
        return int'($urandom_range(6, 25));
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        logic [KEY_W-1:0] v;
        int unsigned      r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            v = KEY_W'($urandom_range(0, 6));
            v = v - KEY_W'(3);
        end else if (r < 55) begin
            case ($urandom_range(0, 3))
                0: v = KEY_MIN;
                1: v = KEY_MAX;
                2: v = '0;
                default: v = '1;
            endcase
        end else begin
            v = {$urandom, $urandom};
        end
        return v;
    endfunction

    function automatic t_record rand_record(input logic last);
        t_record r;
        r.row_id   = $urandom;
        r.score    = $urandom;
        r.key_a    = rand_key();
        r.key_a_na = ($urandom_range(0, 4) == 0);
        r.key_b    = rand_key();
        r.key_b_na = ($urandom_range(0, 4) == 0);
        r.last     = last;
        return r;
    endfunction

    function automatic t_record make_record(input logic [31:0] row, input logic [31:0] score,
                                            input logic [KEY_W-1:0] ka, input logic a_na,
                                            input logic [KEY_W-1:0] kb, input logic b_na,
                                            input logic last);
        t_record r;
        r.row_id   = row;
        r.score    = score;
        r.key_a    = ka;
        r.key_a_na = a_na;
        r.key_b    = kb;
        r.key_b_na = b_na;
        r.last     = last;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (slice_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, got row id %h",
                         $time, o_out_row_id);
                mismatch_count++;
            end else begin
                want = slice_queue.pop_front();
                check_field("out_row_id", want.row_id, o_out_row_id);
                check_field("out_score_bits", want.score, o_out_score_bits);
                check_field("record_valid", 32'(want.valid), 32'(o_record_valid));
                check_field("overflowed", 32'(want.ovf), 32'(o_overflowed));
                check_field("last_result", 32'(want.last), 32'(o_last_result));
            end
        end
    end

    // consumer side
    initial begin
        int n;
        forever begin
            if (hold_off_cycles > 0) begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                n = pick_gap();
                if (n == 0) begin
                    i_out_ready <= 1'b1;
                    @(posedge i_clk);
                end else begin
                    i_out_ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_record(input t_record r);
        int g;
        i_in_valid    <= 1'b1;
        i_row_id      <= r.row_id;
        i_score_bits  <= r.score;
        i_key_a       <= r.key_a;
        i_key_a_na    <= r.key_a_na;
        i_key_b       <= r.key_b;
        i_key_b_na    <= r.key_b_na;
        i_last_record <= r.last;
        do @(posedge i_clk); while (!o_in_ready);
        absorb_record(r);
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_set(input t_record recs[$]);
        foreach (recs[k]) send_record(recs[k]);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (slice_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_SLICE_OFFSET:     cfg_offset = value[CFG_W-1:0];
            REG_SLICE_LIMIT:      cfg_limit  = value[CFG_W-1:0];
            REG_KEY_A_DESCENDING: cfg_a_desc = value[0];
            REG_KEY_B_ENABLED:    cfg_b_en   = value[0];
            REG_KEY_B_DESCENDING: cfg_b_desc = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int offset, input int limit, input logic a_desc,
                              input logic b_en, input logic b_desc);
        write_register(REG_SLICE_OFFSET, offset);
        write_register(REG_SLICE_LIMIT, limit);
        write_register(REG_KEY_A_DESCENDING, 32'(a_desc));
        write_register(REG_KEY_B_ENABLED, 32'(b_en));
        write_register(REG_KEY_B_DESCENDING, 32'(b_desc));
    endtask

    task automatic test_extremes();
        t_record recs[$];
        recs.push_back(make_record(32'h0, 32'h0, KEY_MIN, 1'b0, '0, 1'b0, 1'b0));
        recs.push_back(make_record('1, '1, KEY_MAX, 1'b0, '1, 1'b1, 1'b0));
        recs.push_back(make_record(32'h1, 32'hA5A5_A5A5, '0, 1'b0, KEY_MAX, 1'b0, 1'b0));
        recs.push_back(make_record(32'h2, 32'h5A5A_5A5A, '1, 1'b0, KEY_MIN, 1'b0, 1'b0));
        recs.push_back(make_record(32'h3, 32'h1, {$urandom, $urandom}, 1'b1, '0, 1'b0, 1'b0));
        recs.push_back(make_record(32'h4, 32'h2, KEY_MIN, 1'b0, '0, 1'b0, 1'b1));
        send_set(recs);
        wait_drained();
        write_register(REG_KEY_A_DESCENDING, 1);
        send_set(recs);
    endtask

    task automatic test_two_keys();
        t_record recs[$];
        wait_drained();
        set_config(0, 64, 1'b0, 1'b1, 1'b1);
        recs.push_back(make_record(32'h10, 32'h0, 64'd5, 1'b0, 64'd10, 1'b0, 1'b0));
        recs.push_back(make_record(32'h11, 32'h1, 64'd5, 1'b0, -64'sd10, 1'b0, 1'b0));
        recs.push_back(make_record(32'h12, 32'h2, 64'd5, 1'b0, 64'd0, 1'b1, 1'b0));
        recs.push_back(make_record(32'h13, 32'h3, 64'd5, 1'b1, 64'd7, 1'b0, 1'b0));
        recs.push_back(make_record(32'h14, 32'h4, 64'd5, 1'b0, 64'd3, 1'b1, 1'b0));
        recs.push_back(make_record(32'h15, 32'h5, 64'd5, 1'b0, 64'd10, 1'b0, 1'b1));
        send_set(recs);
    endtask

    task automatic test_empty_slice();
        t_record recs[$];
        wait_drained();
        set_config(3, 64, 1'b0, 1'b0, 1'b0);
        recs.push_back(rand_record(1'b0));
        recs.push_back(rand_record(1'b1));
        send_set(recs);
        wait_drained();
        set_config(0, 0, 1'b1, 1'b0, 1'b0);
        recs = {};
        recs.push_back(rand_record(1'b1));
        send_set(recs);
        wait_drained();
        set_config(64, 64, 1'b0, 1'b0, 1'b0);
        recs = {};
        recs.push_back(rand_record(1'b1));
        send_set(recs);
    endtask

    task automatic test_long_limit();
        t_record recs[$];
        wait_drained();
        set_config(1, 64, 1'b0, 1'b1, 1'b0);
        recs.push_back(rand_record(1'b0));
        recs.push_back(rand_record(1'b0));
        recs.push_back(rand_record(1'b1));
        send_set(recs);
    endtask

    task automatic test_unknown_register();
        t_record recs[$];
        wait_drained();
        set_config(0, 64, 1'b0, 1'b0, 1'b0);
        write_register(REG_NONE, 32'hFFFF_FFFF);
        recs.push_back(rand_record(1'b0));
        recs.push_back(rand_record(1'b1));
        send_set(recs);
    endtask

    task automatic test_overflow();
        t_record recs[$];
        wait_drained();
        set_config(0, 64, 1'b0, 1'b1, 1'b1);
        for (int k = 0; k < CAP; k++) recs.push_back(rand_record(1'b0));
        recs.push_back(rand_record(1'b1));
        send_set(recs);
        recs = {};
        for (int k = 0; k < CAP + 2; k++) recs.push_back(rand_record(1'b0));
        recs.push_back(rand_record(1'b1));
        send_set(recs);
        wait_drained();
        set_config(60, 64, 1'b1, 1'b0, 1'b0);
        recs = {};
        for (int k = 0; k < CAP + 1; k++) recs.push_back(rand_record(1'b0));
        recs.push_back(rand_record(1'b1));
        send_set(recs);
    endtask

    task automatic test_backpressure();
        t_record recs[$];
        wait_drained();
        set_config(0, 64, 1'b0, 1'b0, 1'b0);
        steady = 1'b1;
        hold_off_cycles = 400;
        for (int k = 0; k < 8; k++) recs.push_back(rand_record(k == 7));
        for (int k = 0; k < 30; k++) recs.push_back(rand_record(k == 29));
        send_set(recs);
        steady = 1'b0;
    endtask

    task automatic test_random();
        t_record recs[$];
        int      sent, size, pick, offset, limit;
        sent = 0;
        while (sent < 240) begin
            if (sent == 0 || $urandom_range(0, 2) == 0) begin
                wait_drained();
                case ($urandom_range(0, 9))
                    0: offset = 64;
                    1, 2: offset = int'($urandom_range(0, 64));
                    default: offset = int'($urandom_range(0, 3));
                endcase
                case ($urandom_range(0, 9))
                    0: limit = 0;
                    1: limit = 64;
                    2, 3: limit = int'($urandom_range(0, 64));
                    default: limit = int'($urandom_range(1, 8));
                endcase
                set_config(offset, limit, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            end
            steady = ($urandom_range(0, 4) == 0);
            pick = int'($urandom_range(0, 99));
            if (pick < 70) size = int'($urandom_range(1, 10));
            else if (pick < 90) size = int'($urandom_range(11, 40));
            else if (pick < 97) size = int'($urandom_range(41, 64));
            else size = int'($urandom_range(65, 68));
            recs = {};
            for (int k = 0; k < size; k++) recs.push_back(rand_record(k == size - 1));
            send_set(recs);
            sent += size;
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_two_keys();
        test_empty_slice();
        test_long_limit();
        test_unknown_register();
        test_overflow();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[multi_key_sort_offset_limit_core] OK");
        end else begin
            $display("[multi_key_sort_offset_limit_core] ERROR");
        end
        $finish;
    end

    initial begin
        #1600000;
        $display("[multi_key_sort_offset_limit_core] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
sv/mksol_pkg.sv
sv/mksol_cell.sv
sv/multi_key_sort_offset_limit_core.sv
tb/sv/multi_key_sort_offset_limit_core_test.sv
